@@ rtl/i2c_target_register_sequence_responder_defines.svh @@
// assertion macros for the register sequence responder checker
`ifndef I2C_TARGET_REGISTER_SEQUENCE_RESPONDER_DEFINES_SVH
`define I2C_TARGET_REGISTER_SEQUENCE_RESPONDER_DEFINES_SVH

// checked only out of reset
`define ITRSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked during reset as well
`define ITRSR_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/itrsr_pkg.sv @@
// types, constants and codes shared by the register sequence responder
package itrsr_pkg;

  localparam int unsigned SLOTS      = 8;
  localparam int unsigned DATA_DEPTH = 256;
  localparam int unsigned MAX_MSG    = 32;
  localparam int unsigned MAX_ENTRY  = 16;
  localparam int unsigned MAX_SEQ    = 16;

  localparam int unsigned SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned SLOT_CNT_W = $clog2(SLOTS + 1);
  localparam int unsigned DATA_AW    = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
  localparam int unsigned MSG_CNT_W  = $clog2(MAX_MSG + 1);
  localparam int unsigned SEQ_IDX_W  = (MAX_SEQ > 1) ? $clog2(MAX_SEQ) : 1;

  localparam int unsigned DEV_ADDR_W = 7;
  localparam int unsigned MSG_LEN_W  = 6;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned ENTRY_W    = 5;
  localparam int unsigned SEQ_LEN_W  = 5;
  localparam int unsigned CMP_W      = 8;

  typedef enum logic [1:0] {
    FUNC_DEFINE = 2'd0,
    FUNC_LOAD   = 2'd1,
    FUNC_WRITE  = 2'd2,
    FUNC_READ   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK            = 2'd0,
    STAT_ADDR_MISMATCH = 2'd1,
    STAT_TABLE_FULL    = 2'd2,
    STAT_NO_DATA       = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CTRL_IDLE,
    CTRL_DECODE,
    CTRL_SETUP,
    CTRL_STREAM
  } ctrl_state_e;

  typedef struct packed {
    logic [1:0]            func;
    logic [DEV_ADDR_W-1:0] bus_address;
    logic [MSG_LEN_W-1:0]  msg_len;
    logic [BYTE_W-1:0]     write_byte;
    logic [BYTE_W-1:0]     reg_id;
    logic [ENTRY_W-1:0]    entry_bytes;
    logic [SEQ_LEN_W-1:0]  sequence_length;
    logic [BYTE_W-1:0]     table_base;
    logic [BYTE_W-1:0]     load_offset;
    logic [BYTE_W-1:0]     load_value;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic              data_valid;
    logic              last;
    logic [1:0]        status;
  } result_t;

  typedef struct packed {
    logic    capture;
    logic    def_wr;
    logic    load_wr;
    logic    ptr_wr;
    logic    lookup;
    logic    setup;
    logic    stream;
    logic    emit;
    status_e emit_status;
  } ctrl_cmd_t;

  typedef struct packed {
    func_e func;
    logic  addr_match;
    logic  table_full;
    logic  len_zero;
    logic  found;
    logic  last_byte;
  } dp_status_t;

endpackage

@@ rtl/itrsr_ctrl.sv @@
// controller state machine of the register sequence responder
module itrsr_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  itrsr_pkg::dp_status_t  status_i,
  output logic                   busy_o,
  output itrsr_pkg::ctrl_cmd_t   cmd_o
);

  itrsr_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itrsr_pkg::CTRL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      itrsr_pkg::CTRL_IDLE: begin
        if (start_i) state_d = itrsr_pkg::CTRL_DECODE;
      end
      itrsr_pkg::CTRL_DECODE: begin
        if (status_i.func == itrsr_pkg::FUNC_READ && status_i.addr_match) begin
          state_d = itrsr_pkg::CTRL_SETUP;
        end else begin
          state_d = itrsr_pkg::CTRL_IDLE;
        end
      end
      itrsr_pkg::CTRL_SETUP: begin
        state_d = status_i.len_zero ? itrsr_pkg::CTRL_IDLE : itrsr_pkg::CTRL_STREAM;
      end
      itrsr_pkg::CTRL_STREAM: begin
        if (status_i.last_byte) state_d = itrsr_pkg::CTRL_IDLE;
      end
      default: state_d = itrsr_pkg::CTRL_IDLE;
    endcase
  end

  always_comb begin
    cmd_o             = '0;
    cmd_o.emit_status = itrsr_pkg::STAT_OK;
    busy_o            = (state_q != itrsr_pkg::CTRL_IDLE);
    unique case (state_q)
      itrsr_pkg::CTRL_IDLE: begin
        cmd_o.capture = start_i;
      end
      itrsr_pkg::CTRL_DECODE: begin
        unique case (status_i.func)
          itrsr_pkg::FUNC_DEFINE: begin
            cmd_o.emit = 1'b1;
            if (status_i.table_full) begin
              cmd_o.emit_status = itrsr_pkg::STAT_TABLE_FULL;
            end else begin
              cmd_o.def_wr = 1'b1;
            end
          end
          itrsr_pkg::FUNC_LOAD: begin
            cmd_o.emit    = 1'b1;
            cmd_o.load_wr = 1'b1;
          end
          itrsr_pkg::FUNC_WRITE: begin
            cmd_o.emit = 1'b1;
            if (!status_i.addr_match) begin
              cmd_o.emit_status = itrsr_pkg::STAT_ADDR_MISMATCH;
            end else begin
              cmd_o.ptr_wr = !status_i.len_zero;
            end
          end
          itrsr_pkg::FUNC_READ: begin
            if (!status_i.addr_match) begin
              cmd_o.emit        = 1'b1;
              cmd_o.emit_status = itrsr_pkg::STAT_ADDR_MISMATCH;
            end else begin
              cmd_o.lookup = 1'b1;
            end
          end
          default: cmd_o.emit = 1'b1;
        endcase
      end
      itrsr_pkg::CTRL_SETUP: begin
        cmd_o.setup = 1'b1;
        if (status_i.len_zero) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_status = status_i.found ? itrsr_pkg::STAT_OK : itrsr_pkg::STAT_NO_DATA;
        end
      end
      itrsr_pkg::CTRL_STREAM: begin
        cmd_o.stream = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

@@ rtl/itrsr_dp.sv @@
// datapath: slot table, data memory, read address generation and result register
module itrsr_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [itrsr_pkg::DEV_ADDR_W-1:0]       cfg_wdata_i,
  input  itrsr_pkg::item_t                       item_i,
  input  itrsr_pkg::ctrl_cmd_t                   cmd_i,
  output itrsr_pkg::dp_status_t                  status_o,
  output logic                                   strobe_o,
  output itrsr_pkg::result_t                     result_o
);

  localparam int unsigned SW  = itrsr_pkg::SLOT_IDX_W;
  localparam int unsigned CW  = itrsr_pkg::SLOT_CNT_W;
  localparam int unsigned AW  = itrsr_pkg::DATA_AW;
  localparam int unsigned NW  = itrsr_pkg::MSG_CNT_W;
  localparam int unsigned IW  = itrsr_pkg::SEQ_IDX_W;
  localparam int unsigned EW  = itrsr_pkg::ENTRY_W;
  localparam int unsigned QW  = itrsr_pkg::SEQ_LEN_W;
  localparam int unsigned BW  = itrsr_pkg::BYTE_W;
  localparam int unsigned PW  = IW + EW;

  logic [itrsr_pkg::DEV_ADDR_W-1:0] dev_addr_q;
  logic [BW-1:0]                    ptr_q;
  logic [CW-1:0]                    slot_cnt_q;
  itrsr_pkg::item_t                 item_q;

  logic [BW-1:0] slot_reg_q  [itrsr_pkg::SLOTS];
  logic [EW-1:0] slot_eb_q   [itrsr_pkg::SLOTS];
  logic [QW-1:0] slot_seq_q  [itrsr_pkg::SLOTS];
  logic [BW-1:0] slot_base_q [itrsr_pkg::SLOTS];
  logic [IW-1:0] slot_idx_q  [itrsr_pkg::SLOTS];

  logic [BW-1:0] mem [itrsr_pkg::DATA_DEPTH];
  logic [BW-1:0] mem_rdata_q;

  logic          found_q;
  logic [SW-1:0] hit_q;
  logic [EW-1:0] eb_q;
  logic [NW-1:0] n_q;
  logic [NW-1:0] k_q;
  logic [AW-1:0] rd_addr_q;

  logic               strobe_q;
  itrsr_pkg::result_t res_q;
  logic               from_mem_q;

  logic          match_found;
  logic [SW-1:0] match_idx;
  logic [SW-1:0] slot_wr_idx;
  logic [EW-1:0] eb_clamp;
  logic [QW-1:0] seq_clamp;
  logic [NW-1:0] n_c;
  logic [PW-1:0] prod;
  logic [AW-1:0] start_addr;
  logic [IW-1:0] idx_next;
  logic          last_byte;
  logic          pad;

  // first defined slot whose id equals the register pointer
  always_comb begin
    match_found = 1'b0;
    match_idx   = '0;
    for (int s = itrsr_pkg::SLOTS - 1; s >= 0; s--) begin
      if (CW'(s) < slot_cnt_q && slot_reg_q[s] == ptr_q) begin
        match_found = 1'b1;
        match_idx   = SW'(s);
      end
    end
  end

  assign slot_wr_idx = slot_cnt_q[SW-1:0];

  always_comb begin
    if (item_q.entry_bytes > EW'(itrsr_pkg::MAX_ENTRY)) begin
      eb_clamp = EW'(itrsr_pkg::MAX_ENTRY);
    end else begin
      eb_clamp = item_q.entry_bytes;
    end
    if (item_q.sequence_length == '0) begin
      seq_clamp = QW'(1);
    end else if (item_q.sequence_length > QW'(itrsr_pkg::MAX_SEQ)) begin
      seq_clamp = QW'(itrsr_pkg::MAX_SEQ);
    end else begin
      seq_clamp = item_q.sequence_length;
    end
    if (item_q.msg_len > itrsr_pkg::MSG_LEN_W'(itrsr_pkg::MAX_MSG)) begin
      n_c = NW'(itrsr_pkg::MAX_MSG);
    end else begin
      n_c = NW'(item_q.msg_len);
    end
  end

  assign prod       = PW'(slot_idx_q[hit_q]) * PW'(slot_eb_q[hit_q]);
  assign start_addr = AW'(slot_base_q[hit_q]) + AW'(prod);
  assign idx_next   = ((QW'(slot_idx_q[hit_q]) + QW'(1)) == slot_seq_q[hit_q]) ?
                      '0 : slot_idx_q[hit_q] + IW'(1);
  assign last_byte  = (k_q + NW'(1)) == n_q;
  assign pad        = !found_q || (itrsr_pkg::CMP_W'(k_q) >= itrsr_pkg::CMP_W'(eb_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= '0;
      ptr_q      <= '0;
      slot_cnt_q <= '0;
      strobe_q   <= 1'b0;
    end else begin
      if (cfg_we_i) dev_addr_q <= cfg_wdata_i;
      if (cmd_i.ptr_wr) ptr_q <= item_q.write_byte;
      if (cmd_i.def_wr) slot_cnt_q <= slot_cnt_q + CW'(1);
      strobe_q <= cmd_i.emit || cmd_i.stream;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= item_i;
    if (cmd_i.def_wr) begin
      slot_reg_q[slot_wr_idx]  <= item_q.reg_id;
      slot_eb_q[slot_wr_idx]   <= eb_clamp;
      slot_seq_q[slot_wr_idx]  <= seq_clamp;
      slot_base_q[slot_wr_idx] <= item_q.table_base;
      slot_idx_q[slot_wr_idx]  <= '0;
    end else if (cmd_i.setup && found_q) begin
      slot_idx_q[hit_q] <= idx_next;
    end
    if (cmd_i.lookup) begin
      found_q <= match_found;
      hit_q   <= match_idx;
    end
    if (cmd_i.setup) begin
      eb_q      <= slot_eb_q[hit_q];
      rd_addr_q <= start_addr;
      n_q       <= n_c;
      k_q       <= '0;
    end else if (cmd_i.stream) begin
      k_q       <= k_q + NW'(1);
      rd_addr_q <= rd_addr_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr) mem[AW'(item_q.load_offset)] <= item_q.load_value;
    if (cmd_i.stream) mem_rdata_q <= mem[rd_addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_q.read_data  <= '0;
      res_q.data_valid <= 1'b0;
      res_q.last       <= 1'b1;
      res_q.status     <= cmd_i.emit_status;
      from_mem_q       <= 1'b0;
    end else if (cmd_i.stream) begin
      res_q.read_data  <= '0;
      res_q.data_valid <= 1'b1;
      res_q.last       <= last_byte;
      res_q.status     <= found_q ? itrsr_pkg::STAT_OK : itrsr_pkg::STAT_NO_DATA;
      from_mem_q       <= !pad;
    end
  end

  always_comb begin
    result_o = res_q;
    if (from_mem_q) result_o.read_data = mem_rdata_q;
  end

  assign strobe_o = strobe_q;

  always_comb begin
    status_o.func       = itrsr_pkg::func_e'(item_q.func);
    status_o.addr_match = (item_q.bus_address == dev_addr_q);
    status_o.table_full = (slot_cnt_q >= CW'(itrsr_pkg::SLOTS));
    status_o.len_zero   = (item_q.msg_len == '0);
    status_o.found      = found_q;
    status_o.last_byte  = last_byte;
  end

endmodule

@@ rtl/i2c_target_register_sequence_responder.sv @@
// top level of the i2c target register sequence responder
// set-up, bus write and mismatched items give their word from the decode state, registered
// a read passes decode, set-up and stream states: with msg_len 0 its word comes from set-up,
// else min(msg_len, 32) words come from stream, one per cycle; new items wait for idle
// the read rate is set by the single read port of the data memory, one byte per cycle
// results cannot be stalled; reset clears pointer, slot count and device address to zero
module i2c_target_register_sequence_responder (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [itrsr_pkg::DEV_ADDR_W-1:0] cfg_wdata_i,
  input  logic                             start,
  input  itrsr_pkg::item_t                 item_i,
  output logic                             busy,
  output logic                             strobe_o,
  output itrsr_pkg::result_t               result_o
);

  itrsr_pkg::ctrl_cmd_t  cmd;
  itrsr_pkg::dp_status_t dp_status;

  itrsr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (dp_status),
    .busy_o   (busy),
    .cmd_o    (cmd)
  );

  itrsr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_i),
    .cmd_i       (cmd),
    .status_o    (dp_status),
    .strobe_o    (strobe_o),
    .result_o    (result_o)
  );

endmodule

@@ rtl/itrsr_checker.sv @@
// port-level checker for the register sequence responder and its bind
`include "i2c_target_register_sequence_responder_defines.svh"

module itrsr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               strobe_o,
  input itrsr_pkg::result_t result_o
);

  `ITRSR_ASSERT_ANY(a_quiet_in_reset, !rst_ni |=> (!strobe_o && !busy), "word or busy in reset")
  `ITRSR_ASSERT(a_start_busy, (start && !busy) |=> busy, "accepted start did not raise busy")
  `ITRSR_ASSERT(a_burst_contiguous, (strobe_o && !result_o.last) |=> strobe_o, "gap in burst")
  `ITRSR_ASSERT(a_single_is_last, strobe_o && !result_o.data_valid |-> result_o.last, "not last")

endmodule

bind i2c_target_register_sequence_responder itrsr_checker u_itrsr_checker (.*);

@@ sim/tb.sv @@
// self-checking testbench for the i2c target register sequence responder
module tb;
  import itrsr_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned REPORT_LIMIT   = 10;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [DEV_ADDR_W-1:0] cfg_wdata_i;
  logic                  start;
  item_t                 item_i;
  logic                  busy;
  logic                  strobe_o;
  result_t               result_o;

  i2c_target_register_sequence_responder uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .start      (start),
    .item_i     (item_i),
    .busy       (busy),
    .strobe_o   (strobe_o),
    .result_o   (result_o)
  );

  logic [DEV_ADDR_W-1:0] dev_addr_m = '0;
  logic [7:0]            reg_ptr_m = '0;
  int unsigned           slots_used = 0;
  logic [7:0]            slot_id_m   [SLOTS];
  int unsigned           slot_len_m  [SLOTS];
  int unsigned           slot_seq_m  [SLOTS];
  logic [7:0]            slot_base_m [SLOTS];
  int unsigned           slot_pos_m  [SLOTS];
  logic [7:0]            mem_m       [DATA_DEPTH];
  bit                    mem_loaded  [DATA_DEPTH];

  result_t     reply_queue[$];
  int unsigned mismatches = 0;
  int unsigned words_checked = 0;
  int unsigned items_sent = 0;
  int unsigned reads_sent = 0;
  int unsigned idle_cycles = 0;
  bit          no_gaps = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic void queue_word(logic [7:0] data, logic valid, logic last, status_e st);
    result_t w;
    w.read_data  = data;
    w.data_valid = valid;
    w.last       = last;
    w.status     = st;
    reply_queue = {reply_queue, w};
  endfunction

  function automatic int find_slot(logic [7:0] id);
    for (int s = 0; s < int'(slots_used); s++) begin
      if (slot_id_m[s] == id) return s;
    end
    return -1;
  endfunction

  function automatic int unsigned read_addr(int s, int unsigned k);
    return (slot_base_m[s] + slot_pos_m[s] * slot_len_m[s] + k) % DATA_DEPTH;
  endfunction

  function automatic void predict_target_reply(item_t it);
    int unsigned n;
    int unsigned seq;
    int unsigned eb;
    int          s;
    status_e     st;
    case (func_e'(it.func))
      FUNC_DEFINE: begin
        if (slots_used >= SLOTS) begin
          queue_word(8'h00, 1'b0, 1'b1, STAT_TABLE_FULL);
        end else begin
          seq = it.sequence_length;
          if (seq == 0) seq = 1;
          if (seq > MAX_SEQ) seq = MAX_SEQ;
          eb = it.entry_bytes;
          if (eb > MAX_ENTRY) eb = MAX_ENTRY;
          slot_id_m[slots_used]   = it.reg_id;
          slot_len_m[slots_used]  = eb;
          slot_seq_m[slots_used]  = seq;
          slot_base_m[slots_used] = it.table_base;
          slot_pos_m[slots_used]  = 0;
          slots_used++;
          queue_word(8'h00, 1'b0, 1'b1, STAT_OK);
        end
      end
      FUNC_LOAD: begin
        mem_m[it.load_offset]      = it.load_value;
        mem_loaded[it.load_offset] = 1'b1;
        queue_word(8'h00, 1'b0, 1'b1, STAT_OK);
      end
      default: begin
        if (it.bus_address != dev_addr_m) begin
          queue_word(8'h00, 1'b0, 1'b1, STAT_ADDR_MISMATCH);
        end else if (func_e'(it.func) == FUNC_WRITE) begin
          if (it.msg_len != 0) reg_ptr_m = it.write_byte;
          queue_word(8'h00, 1'b0, 1'b1, STAT_OK);
        end else begin
          n = it.msg_len;
          if (n > MAX_MSG) n = MAX_MSG;
          s = find_slot(reg_ptr_m);
          st = (s < 0) ? STAT_NO_DATA : STAT_OK;
          if (n == 0) queue_word(8'h00, 1'b0, 1'b1, st);
          for (int unsigned k = 0; k < n; k++) begin
            queue_word((s >= 0 && k < slot_len_m[s]) ? mem_m[read_addr(s, k)] : 8'h00,
                       1'b1, k + 1 == n, st);
          end
          if (s >= 0) slot_pos_m[s] = (slot_pos_m[s] + 1) % slot_seq_m[s];
        end
      end
    endcase
  endfunction

  function automatic item_t noise_item();
    logic [95:0] r;
    r = {$urandom(), $urandom(), $urandom()};
    return item_t'(r[$bits(item_t)-1:0]);
  endfunction

  function automatic void log_mismatch(string what, result_t want, result_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("mismatch %0d (%s): expected data=%02h valid=%b last=%b status=%0d",
               mismatches, what, want.read_data, want.data_valid, want.last, want.status);
      $display("  got data=%02h valid=%b last=%b status=%0d",
               got.read_data, got.data_valid, got.last, got.status);
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && strobe_o === 1'b1) begin
      if (reply_queue.size() == 0) begin
        log_mismatch("word with nothing pending", '0, result_o);
      end else begin
        want = reply_queue.pop_front();
        words_checked++;
        if (result_o.read_data !== want.read_data || result_o.data_valid !== want.data_valid ||
            result_o.last !== want.last || result_o.status !== want.status)
          log_mismatch("word", want, result_o);
      end
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if (!rst_ni || strobe_o === 1'b1 || (start && busy === 1'b0)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d words pending", reply_queue.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_word(input item_t it);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    predict_target_reply(it);
    items_sent++;
    if (func_e'(it.func) == FUNC_READ) reads_sent++;
  endtask

  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    while (reply_queue.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_device_address(input logic [DEV_ADDR_W-1:0] value);
    settle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    dev_addr_m = value;
  endtask

  task automatic define_slot(input logic [7:0] id, input logic [4:0] eb,
                             input logic [4:0] seq, input logic [7:0] base);
    item_t it;
    it = noise_item();
    it.func            = FUNC_DEFINE;
    it.reg_id          = id;
    it.entry_bytes     = eb;
    it.sequence_length = seq;
    it.table_base      = base;
    send_word(it);
  endtask

  task automatic load_byte(input logic [7:0] offset, input logic [7:0] value);
    item_t it;
    it = noise_item();
    it.func        = FUNC_LOAD;
    it.load_offset = offset;
    it.load_value  = value;
    send_word(it);
  endtask

  task automatic bus_write(input logic [6:0] addr, input logic [5:0] len,
                           input logic [7:0] wbyte);
    item_t it;
    it = noise_item();
    it.func        = FUNC_WRITE;
    it.bus_address = addr;
    it.msg_len     = len;
    it.write_byte  = wbyte;
    send_word(it);
  endtask

  // loads any byte of the coming entry that was never written, then reads
  task automatic bus_read(input logic [6:0] addr, input logic [5:0] len);
    item_t       it;
    int          s;
    int unsigned n;
    int unsigned a;
    if (addr == dev_addr_m) begin
      s = find_slot(reg_ptr_m);
      if (s >= 0) begin
        n = len;
        if (n > MAX_MSG) n = MAX_MSG;
        for (int unsigned k = 0; k < n && k < slot_len_m[s]; k++) begin
          a = read_addr(s, k);
          if (!mem_loaded[a]) load_byte(8'(a), 8'($urandom()));
        end
      end
    end
    it = noise_item();
    it.func        = FUNC_READ;
    it.bus_address = addr;
    it.msg_len     = len;
    send_word(it);
  endtask

  function automatic logic [5:0] random_read_len();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return 6'd0;
    if (pick == 1) return 6'($urandom_range(33, 63));
    if (pick < 6) return 6'($urandom_range(9, 32));
    return 6'($urandom_range(1, 8));
  endfunction

  task automatic test_reset_state();
    bus_write(7'h00, 6'd0, 8'h5A);
    bus_read(7'h00, 6'd2);
    bus_read(7'h00, 6'd0);
  endtask

  task automatic test_slot_table();
    logic [7:0] extra_ids [3] = '{8'hC3, 8'h81, 8'h7E};
    set_device_address(7'h7F);
    define_slot(8'h00, 5'd1, 5'd0, 8'h00);
    define_slot(8'hFF, 5'd16, 5'd16, 8'hFF);
    define_slot(8'h5A, 5'd31, 5'd31, 8'h80);
    define_slot(8'h33, 5'd0, 5'd3, 8'h10);
    define_slot(8'h5A, 5'd4, 5'd2, 8'h40);
    foreach (extra_ids[i])
      define_slot(extra_ids[i], 5'($urandom_range(1, 16)), 5'($urandom_range(1, 16)),
                  8'($urandom()));
    // table full from here on
    define_slot(8'($urandom()), 5'($urandom()), 5'($urandom()), 8'($urandom()));
    define_slot(8'h99, 5'd31, 5'd31, 8'hFF);
    load_byte(8'h00, 8'hFF);
    load_byte(8'hFF, 8'h00);
  endtask

  task automatic test_bus_messages();
    bus_write(7'h7E, 6'd1, 8'h00);
    bus_read(7'h3F, 6'd4);
    bus_write(7'h7F, 6'd0, 8'hAA);
    bus_read(7'h7F, 6'd3);
    bus_write(7'h7F, 6'd63, 8'hFF);
    bus_read(7'h7F, 6'd63);
    bus_read(7'h7F, 6'd16);
    bus_write(7'h7F, 6'd1, 8'h5A);
    bus_read(7'h7F, 6'd20);
    bus_write(7'h7F, 6'd2, 8'h33);
    bus_read(7'h7F, 6'd4);
    bus_read(7'h7F, 6'd0);
    bus_write(7'h7F, 6'd1, 8'h99);
    bus_read(7'h7F, 6'd5);
    bus_read(7'h7F, 6'd0);
    set_device_address(7'h00);
    bus_write(7'h00, 6'd1, 8'hFF);
    bus_read(7'h00, 6'd1);
    bus_read(7'h7F, 6'd1);
  endtask

  task automatic test_random_traffic(input int unsigned count);
    int unsigned     pick;
    logic [6:0]      dst;
    logic [7:0]      wbyte;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 20 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        wbyte = ($urandom_range(0, 4) == 0) ? 8'($urandom())
                                            : slot_id_m[$urandom_range(0, SLOTS - 1)];
        bus_write(dev_addr_m,
                  ($urandom_range(0, 9) == 0) ? 6'd0 : 6'($urandom_range(1, 63)), wbyte);
      end else if (pick < 70) begin
        bus_read(dev_addr_m, random_read_len());
      end else if (pick < 85) begin
        load_byte(8'($urandom()), 8'($urandom()));
      end else if (pick < 90) begin
        define_slot(8'($urandom()), 5'($urandom()), 5'($urandom()), 8'($urandom()));
      end else begin
        dst = dev_addr_m ^ (7'h01 << $urandom_range(0, 6));
        if (pick < 95) bus_write(dst, 6'($urandom()), 8'($urandom()));
        else bus_read(dst, random_read_len());
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    logic [DEV_ADDR_W-1:0] phase_addr [4];
    rst_ni      = 1'b0;
    start       = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    item_i      = '0;
    phase_addr  = '{7'($urandom()), 7'h7F, 7'h00, 7'($urandom())};
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_slot_table();
    test_bus_messages();
    foreach (phase_addr[p]) begin
      set_device_address(phase_addr[p]);
      test_random_traffic(80);
    end
    settle();

    $display("sent %0d words (%0d bus reads) over several device addresses, checked %0d replies",
             items_sent, reads_sent, words_checked);
    $display("covered slot setup to a full table, data loads, pointer writes and mismatches");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/itrsr_pkg.sv
rtl/itrsr_ctrl.sv
rtl/itrsr_dp.sv
rtl/i2c_target_register_sequence_responder.sv
rtl/itrsr_checker.sv
sim/tb.sv
